// File: hw/rtl/stepper_sine_microstep_sequencer_macros.svh
// ----------------------------------------------------------------------------
// stepper sequencer assertion macros
// shared concurrent assertion forms, reset disables every check
// ----------------------------------------------------------------------------
`ifndef STEPPER_SINE_MICROSTEP_SEQUENCER_MACROS_SVH
`define STEPPER_SINE_MICROSTEP_SEQUENCER_MACROS_SVH

// same-cycle implication
`define SSMS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SSMS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/ssms_pkg.sv
// ----------------------------------------------------------------------------
// ssms_pkg
// shared types, codes and defaults of the stepper microstep sequencer
// ----------------------------------------------------------------------------
package ssms_pkg;

  // default sizing
  localparam int DEF_QUARTER_STEPS   = 64;
  localparam int DEF_CYCLES_PER_TURN = 50;

  // field widths
  localparam int ACTION_W = 2;
  localparam int INDEX_W  = 7;
  localparam int DUTY_W   = 12;
  localparam int TURNS_W  = 8;
  localparam int QUAD_W   = 3;
  localparam int CNT_W    = 14;
  localparam int LIMIT_W  = 8;

  // configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_LIMIT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_DUTY   = 4'd1;

  // register reset values
  localparam int DEF_TURN_LIMIT = 20;
  localparam logic [DUTY_W-1:0] DEF_OFF_DUTY = 12'd1199;

  // item actions
  localparam logic [ACTION_W-1:0] ACT_TICK   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_ENABLE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_WRITE  = 2'd2;

  // quadrants
  localparam logic [QUAD_W-1:0] QUAD_1    = 3'd1;
  localparam logic [QUAD_W-1:0] QUAD_2    = 3'd2;
  localparam logic [QUAD_W-1:0] QUAD_3    = 3'd3;
  localparam logic [QUAD_W-1:0] QUAD_4    = 3'd4;
  localparam logic [QUAD_W-1:0] QUAD_OVER = 3'd5;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic                direction;
    logic [INDEX_W-1:0]  table_index;
    logic [DUTY_W-1:0]   table_value;
  } item_t;

  // control handed from the sequencer to the output stage
  typedef struct packed {
    logic               load;
    logic               on;
    logic               direction;
    logic [QUAD_W-1:0]  quadrant;
    logic               running;
    logic               report;
    logic [TURNS_W-1:0] turns;
    logic [DUTY_W-1:0]  off_duty;
  } tick_ctl_t;

endpackage

// File: hw/rtl/ssms_if.sv
// ----------------------------------------------------------------------------
// ssms_if
// valid/ready channels of the stepper microstep sequencer
// ----------------------------------------------------------------------------
interface ssms_in_if;
  import ssms_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic                direction;
  logic [INDEX_W-1:0]  table_index;
  logic [DUTY_W-1:0]   table_value;

  modport source (output valid, action, direction, table_index, table_value, input ready);
  modport sink (input valid, action, direction, table_index, table_value, output ready);
endinterface

interface ssms_out_if;
  import ssms_pkg::*;

  logic               valid;
  logic               ready;
  logic [DUTY_W-1:0]  duty_a_pos;
  logic [DUTY_W-1:0]  duty_a_neg;
  logic [DUTY_W-1:0]  duty_b_pos;
  logic [DUTY_W-1:0]  duty_b_neg;
  logic               running;
  logic               turn_report;
  logic [TURNS_W-1:0] turns_done;

  modport source (output valid, duty_a_pos, duty_a_neg, duty_b_pos, duty_b_neg, running,
                  turn_report, turns_done, input ready);
  modport sink (input valid, duty_a_pos, duty_a_neg, duty_b_pos, duty_b_neg, running,
                turn_report, turns_done, output ready);
endinterface

interface ssms_cfg_if;
  import ssms_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/stepper_sine_microstep_sequencer.sv
// ----------------------------------------------------------------------------
// stepper_sine_microstep_sequencer
// tick path: table read with the tick stage, then the output register
// throughput: one item per cycle while each result is taken, one table read per tick on the ram
// enable and table-write items give no result
// reset: synchronous, motor stopped, phase 0, quadrant 1, counters clear, table not cleared
// ----------------------------------------------------------------------------
module stepper_sine_microstep_sequencer #(
  parameter int QUARTER_STEPS   = ssms_pkg::DEF_QUARTER_STEPS,
  parameter int CYCLES_PER_TURN = ssms_pkg::DEF_CYCLES_PER_TURN
) (
  input logic       clk,
  input logic       rst,
  ssms_cfg_if.sink  cfg,
  ssms_in_if.sink   item,
  ssms_out_if.source result
);
  import ssms_pkg::*;

  localparam int PW = $clog2(QUARTER_STEPS + 1);

  // item transfer
  logic      item_acc;
  item_t     item_data;
  logic      s1_ready;

  // table ram ports
  logic              ram_we;
  logic [PW-1:0]     ram_waddr;
  logic [DUTY_W-1:0] ram_wdata;
  logic              ram_re;
  logic [PW-1:0]     ram_raddr_sin;
  logic [PW-1:0]     ram_raddr_cos;
  logic [DUTY_W-1:0] sin_val;
  logic [DUTY_W-1:0] cos_val;

  tick_ctl_t ctl;

  // config writes are always taken
  assign cfg.ready = 1'b1;

  // a new item enters whenever the tick stage is free or moving on
  assign item.ready = s1_ready;
  assign item_acc   = item.valid && s1_ready;

  always_comb begin
    item_data.action      = item.action;
    item_data.direction   = item.direction;
    item_data.table_index = item.table_index;
    item_data.table_value = item.table_value;
  end

  // state, counters and table addressing
  ssms_ctrl #(
    .QUARTER_STEPS   (QUARTER_STEPS),
    .CYCLES_PER_TURN (CYCLES_PER_TURN)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg.valid),
    .cfg_index     (cfg.index),
    .cfg_data      (cfg.data),
    .item_acc      (item_acc),
    .item          (item_data),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .ram_re        (ram_re),
    .ram_raddr_sin (ram_raddr_sin),
    .ram_raddr_cos (ram_raddr_cos),
    .ctl           (ctl)
  );

  // quarter-wave table, sine and cosine read together
  ssms_ram #(
    .WIDTH (DUTY_W),
    .DEPTH (QUARTER_STEPS + 1)
  ) u_table (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (ram_re),
    .raddr_a (ram_raddr_sin),
    .raddr_b (ram_raddr_cos),
    .rdata_a (sin_val),
    .rdata_b (cos_val)
  );

  // duty routing and result register
  ssms_route u_route (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .sin_val  (sin_val),
    .cos_val  (cos_val),
    .s1_ready (s1_ready),
    .result   (result)
  );

endmodule

// File: hw/rtl/ssms_ram.sv
// ----------------------------------------------------------------------------
// ssms_ram
// generic ram, one write port, two registered read ports
// ----------------------------------------------------------------------------
module ssms_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 65
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// File: hw/rtl/ssms_ctrl.sv
// ----------------------------------------------------------------------------
// ssms_ctrl
// sequencer state: enable, phase, quadrant, cycle and turn counters, config
// ----------------------------------------------------------------------------
`include "stepper_sine_microstep_sequencer_macros.svh"

module ssms_ctrl #(
  parameter int QUARTER_STEPS   = ssms_pkg::DEF_QUARTER_STEPS,
  parameter int CYCLES_PER_TURN = ssms_pkg::DEF_CYCLES_PER_TURN
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ssms_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ssms_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                item_acc,
  input  ssms_pkg::item_t                     item,
  output logic                                ram_we,
  output logic [$clog2(QUARTER_STEPS+1)-1:0]  ram_waddr,
  output logic [ssms_pkg::DUTY_W-1:0]         ram_wdata,
  output logic                                ram_re,
  output logic [$clog2(QUARTER_STEPS+1)-1:0]  ram_raddr_sin,
  output logic [$clog2(QUARTER_STEPS+1)-1:0]  ram_raddr_cos,
  output ssms_pkg::tick_ctl_t                 ctl
);
  import ssms_pkg::*;

  localparam int PW    = $clog2(QUARTER_STEPS + 1);
  localparam int XW    = (INDEX_W > PW + 1) ? INDEX_W : PW + 1;
  localparam int RW    = (CYCLES_PER_TURN > 1) ? $clog2(CYCLES_PER_TURN) : 1;
  localparam int LW    = $clog2(255 * CYCLES_PER_TURN + 1);
  localparam int CW    = (LW > CNT_W) ? LW : CNT_W;
  localparam logic [PW-1:0] QS_P    = PW'(QUARTER_STEPS);
  localparam logic [XW-1:0] QS_X    = XW'(QUARTER_STEPS);
  localparam logic [RW-1:0] REM_TOP = RW'(CYCLES_PER_TURN - 1);
  localparam logic [LW-1:0] CPT_L   = LW'(CYCLES_PER_TURN);
  localparam logic [LW-1:0] LIM_RST = LW'(DEF_TURN_LIMIT * CYCLES_PER_TURN);

  // state
  logic              motor_on;
  logic [PW-1:0]     phase;
  logic [QUAD_W-1:0] quadrant;
  logic [CNT_W-1:0]  cycles;
  logic [CNT_W-1:0]  turns;
  logic [RW-1:0]     rem;
  logic [LW-1:0]     limit_cycles;
  logic [DUTY_W-1:0] off_duty;

  logic              motor_on_next;
  logic [PW-1:0]     phase_next;
  logic [QUAD_W-1:0] quadrant_next;
  logic [CNT_W-1:0]  cycles_next;
  logic [CNT_W-1:0]  turns_next;
  logic [RW-1:0]     rem_next;

  logic              is_tick;
  logic              wrap;
  logic [PW-1:0]     phase_eff;
  logic [QUAD_W-1:0] quad_inc;
  logic              cyc_done;
  logic [CNT_W-1:0]  cycles_inc;
  logic [CNT_W-1:0]  turns_inc;
  logic [RW-1:0]     rem_inc;
  logic              stop;
  logic [XW-1:0]     index_ext;

  assign is_tick   = item_acc && (item.action == ACT_TICK);
  assign wrap      = (phase >= QS_P);
  assign phase_eff = wrap ? '0 : phase;
  assign quad_inc  = wrap ? quadrant + QUAD_W'(1) : quadrant;
  assign cyc_done  = wrap && (quad_inc >= QUAD_OVER);

  // quotient and remainder by turns follow the cycle count
  always_comb begin
    cycles_inc = cycles + CNT_W'(1);
    if (cycles == '1) begin
      turns_inc = '0;
      rem_inc   = '0;
    end else if (rem == REM_TOP) begin
      turns_inc = turns + CNT_W'(1);
      rem_inc   = '0;
    end else begin
      turns_inc = turns;
      rem_inc   = rem + RW'(1);
    end
  end

  assign stop = cyc_done && (CW'(cycles_inc) >= CW'(limit_cycles));

  always_comb begin
    motor_on_next = motor_on;
    phase_next    = phase;
    quadrant_next = quadrant;
    cycles_next   = cycles;
    turns_next    = turns;
    rem_next      = rem;
    if (item_acc && (item.action == ACT_ENABLE)) begin
      motor_on_next = 1'b1;
    end else if (is_tick && motor_on) begin
      phase_next    = phase_eff + PW'(1);
      quadrant_next = cyc_done ? QUAD_1 : quad_inc;
      if (cyc_done) begin
        cycles_next = stop ? '0 : cycles_inc;
        turns_next  = stop ? '0 : turns_inc;
        rem_next    = stop ? '0 : rem_inc;
      end
      motor_on_next = !stop;
    end else if (is_tick) begin
      cycles_next = '0;
      turns_next  = '0;
      rem_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      motor_on     <= 1'b0;
      phase        <= '0;
      quadrant     <= QUAD_1;
      cycles       <= '0;
      turns        <= '0;
      rem          <= '0;
      limit_cycles <= LIM_RST;
      off_duty     <= DEF_OFF_DUTY;
    end else begin
      motor_on <= motor_on_next;
      phase    <= phase_next;
      quadrant <= quadrant_next;
      cycles   <= cycles_next;
      turns    <= turns_next;
      rem      <= rem_next;
      if (cfg_we && (cfg_index == CFG_TURN_LIMIT)) begin
        limit_cycles <= LW'(cfg_data[LIMIT_W-1:0]) * CPT_L;
      end
      if (cfg_we && (cfg_index == CFG_OFF_DUTY)) begin
        off_duty <= cfg_data[DUTY_W-1:0];
      end
    end
  end

  // table write, out-of-range index dropped
  assign index_ext = XW'(item.table_index);
  assign ram_we    = item_acc && (item.action == ACT_WRITE) && (index_ext <= QS_X);
  assign ram_waddr = index_ext[PW-1:0];
  assign ram_wdata = item.table_value;

  // sine and cosine reads
  assign ram_re        = is_tick && motor_on;
  assign ram_raddr_sin = phase_eff;
  assign ram_raddr_cos = QS_P - phase_eff;

  always_comb begin
    ctl.load      = is_tick;
    ctl.on        = motor_on;
    ctl.direction = item.direction;
    ctl.quadrant  = cyc_done ? QUAD_1 : quad_inc;
    ctl.running   = motor_on && !stop;
    ctl.report    = motor_on && cyc_done;
    ctl.turns     = (motor_on && cyc_done) ? turns_inc[TURNS_W-1:0] : '0;
    ctl.off_duty  = off_duty;
  end

  `SSMS_ASSERT_NOW(a_state_range, clk, rst, 1'b1, (rem <= REM_TOP) && (phase <= QS_P) && (quadrant >= QUAD_1) && (quadrant <= QUAD_4), "sequencer state out of range")
  `SSMS_ASSERT_NOW(a_stop_clears, clk, rst, $fell(motor_on), (cycles == '0) && (turns == '0) && (rem == '0), "stop left counters set")
  `SSMS_ASSERT_NEXT(a_phase_wrap, clk, rst, is_tick && motor_on && wrap, phase == PW'(1), "phase did not restart after a quarter")

endmodule

// File: hw/rtl/ssms_route.sv
// ----------------------------------------------------------------------------
// ssms_route
// tick stage waiting on table data, duty routing and output register
// ----------------------------------------------------------------------------
module ssms_route (
  input  logic                        clk,
  input  logic                        rst,
  input  ssms_pkg::tick_ctl_t         ctl,
  input  logic [ssms_pkg::DUTY_W-1:0] sin_val,
  input  logic [ssms_pkg::DUTY_W-1:0] cos_val,
  output logic                        s1_ready,
  ssms_out_if.source                  result
);
  import ssms_pkg::*;

  logic      s1_valid;
  tick_ctl_t s1;
  logic      s1_adv;

  logic [DUTY_W-1:0] a_p, a_n, b_p, b_n;

  assign s1_adv   = s1_valid && (!result.valid || result.ready);
  assign s1_ready = !s1_valid || s1_adv;

  always_comb begin
    a_p = '0;
    a_n = '0;
    b_p = '0;
    b_n = '0;
    if (!s1.on) begin
      a_p = s1.off_duty;
      a_n = s1.off_duty;
      b_p = s1.off_duty;
      b_n = s1.off_duty;
    end else if (s1.direction) begin
      case (s1.quadrant)
        QUAD_1: begin a_p = cos_val; b_p = sin_val; end
        QUAD_2: begin a_n = sin_val; b_p = cos_val; end
        QUAD_3: begin a_n = cos_val; b_n = sin_val; end
        QUAD_4: begin a_p = sin_val; b_n = cos_val; end
        default: begin end
      endcase
    end else begin
      case (s1.quadrant)
        QUAD_1: begin a_p = cos_val; b_n = sin_val; end
        QUAD_2: begin a_n = sin_val; b_n = cos_val; end
        QUAD_3: begin a_n = cos_val; b_p = sin_val; end
        QUAD_4: begin a_p = sin_val; b_p = cos_val; end
        default: begin end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (ctl.load) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      s1 <= ctl;
    end
    if (s1_adv) begin
      result.duty_a_pos  <= a_p;
      result.duty_a_neg  <= a_n;
      result.duty_b_pos  <= b_p;
      result.duty_b_neg  <= b_n;
      result.running     <= s1.running;
      result.turn_report <= s1.report;
      result.turns_done  <= s1.turns;
    end
  end

endmodule
